### sv/level_set_viscosity_blend_macros.svh
// ----------------------------------------------------------------------------
// Level-set viscosity blend: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LEVEL_SET_VISCOSITY_BLEND_MACROS_SVH
`define LEVEL_SET_VISCOSITY_BLEND_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSVB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSVB_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lsvb_pkg.sv
// ----------------------------------------------------------------------------
// Level-set viscosity blend: package
// Shared widths, fixed-point constants and the sideband flag type.
// ----------------------------------------------------------------------------
package lsvb_pkg;

  // Field and datapath widths
  localparam int unsigned PHI_W   = 32;  // level set, Q16.16 signed
  localparam int unsigned WIDTH_W = 32;  // cell width, Q16.16
  localparam int unsigned VISC_W  = 32;  // viscosities, Q16.16
  localparam int unsigned CELLS_W = 16;  // interface cells, Q8.8
  localparam int unsigned MAG_W   = 32;  // |level set|, up to 2^31
  localparam int unsigned ALPHA_W = 48;  // half-width, Q24.24
  localparam int unsigned NUM_W   = 56;  // divider dividend
  localparam int unsigned QUOT_W  = 17;  // u in Q0.16, up to one
  localparam int unsigned H_W     = 17;  // fluid fraction, Q0.16
  localparam int unsigned SINE_W  = 31;  // sine table entry, Q2.30
  localparam int unsigned FRAC_W  = 15;  // interpolation fraction
  localparam int unsigned PROD_W  = 49;  // viscosity times fraction

  // Fraction codes
  localparam logic [H_W-1:0] H_ONE  = 17'd65536;
  localparam logic [H_W-1:0] H_HALF = 17'd32768;
  localparam logic [H_W-1:0] H_ZERO = 17'd0;

  // Fixed-point constants
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam int unsigned SERIES_TERMS   = 12;
  // (2i)(2i+1) for the Taylor terms of the sine series
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  localparam int unsigned SINE_TABLE_ENTRIES_DEF = 256;

  // Configuration
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [VISC_W-1:0]  FLUID_VISC_RST = 32'd65536;
  localparam logic [VISC_W-1:0]  SOLID_VISC_RST = 32'd65536;
  localparam logic [CELLS_W-1:0] CELLS_RST      = 16'd512;

  // Flags that ride along with a word through the divider
  typedef struct packed {
    logic neg;         // level set negative
    logic mag_zero;    // level set exactly zero
    logic alpha_zero;  // zero half-width: sharp step
    logic beyond;      // |level set| past the half-width
  } side_t;

endpackage

### sv/lsvb_div.sv
// ----------------------------------------------------------------------------
// Level-set viscosity blend: pipelined divider
// Restoring division, one quotient bit per register stage, with a
// per-stage valid bit and a stall chain that fills bubbles.
// ----------------------------------------------------------------------------
module lsvb_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lsvb_pkg::ALPHA_W-1:0]   in_rem_i,
  input  logic [lsvb_pkg::QUOT_W-1:0]    in_low_i,
  input  logic [lsvb_pkg::ALPHA_W-1:0]   in_divisor_i,
  input  lsvb_pkg::side_t                in_side_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lsvb_pkg::QUOT_W-1:0]    out_quot_o,
  output lsvb_pkg::side_t                out_side_o
);

  localparam int unsigned NS = lsvb_pkg::QUOT_W;
  localparam int unsigned AW = lsvb_pkg::ALPHA_W;
  localparam int unsigned QW = lsvb_pkg::QUOT_W;

  logic                 valid_q   [NS];
  logic [AW-1:0]        rem_q     [NS];
  logic [QW-1:0]        low_q     [NS];
  logic [AW-1:0]        divisor_q [NS];
  logic [QW-1:0]        quot_q    [NS];
  lsvb_pkg::side_t      side_q    [NS];
  logic [NS-1:0]        en;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic              prev_valid;
    logic [AW-1:0]     prev_rem;
    logic [QW-1:0]     prev_low;
    logic [AW-1:0]     prev_divisor;
    logic [QW-1:0]     prev_quot;
    lsvb_pkg::side_t   prev_side;
    logic [AW:0]       trial;
    logic [AW:0]       diff;
    logic              take;

    if (j == 0) begin : g_first
      assign prev_valid   = in_valid_i;
      assign prev_rem     = in_rem_i;
      assign prev_low     = in_low_i;
      assign prev_divisor = in_divisor_i;
      assign prev_quot    = '0;
      assign prev_side    = in_side_i;
    end else begin : g_next
      assign prev_valid   = valid_q[j-1];
      assign prev_rem     = rem_q[j-1];
      assign prev_low     = low_q[j-1];
      assign prev_divisor = divisor_q[j-1];
      assign prev_quot    = quot_q[j-1];
      assign prev_side    = side_q[j-1];
    end

    if (j == NS - 1) begin : g_en_last
      assign en[j] = !valid_q[j] || out_ready_i;
    end else begin : g_en_mid
      assign en[j] = !valid_q[j] || en[j+1];
    end

    // Bring down the next dividend bit, subtract the divisor if it fits
    assign trial = {prev_rem, prev_low[QW-1]};
    assign diff  = trial - {1'b0, prev_divisor};
    assign take  = (trial >= {1'b0, prev_divisor});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en[j]) begin
        valid_q[j] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        rem_q[j]     <= take ? diff[AW-1:0] : trial[AW-1:0];
        low_q[j]     <= {prev_low[QW-2:0], 1'b0};
        divisor_q[j] <= prev_divisor;
        quot_q[j]    <= {prev_quot[QW-2:0], take};
        side_q[j]    <= prev_side;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];
  assign out_quot_o  = quot_q[NS-1];
  assign out_side_o  = side_q[NS-1];

endmodule

### sv/level_set_viscosity_blend.sv
// Throughput: one word per cycle while out_stall_i holds nothing back; every stage
// advances whenever the stage after it is empty or moving, so bubbles fill and a
// stalled output holds only what is behind it.
// The 17-stage restoring divider (one quotient bit per stage) sets the depth.
// Reset: rst_ni asynchronous, active low; clears all valid bits and restores the
// configuration defaults. The sine table is constant, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Level-set viscosity blend
// Sine-smoothed Heaviside of the level set over a half-width of
// interface_cells * cell_width, then a linear blend of fluid and solid
// viscosity by that fraction, saturated to Q16.16.
// ----------------------------------------------------------------------------
module level_set_viscosity_blend #(
  parameter int unsigned SINE_TABLE_ENTRIES = lsvb_pkg::SINE_TABLE_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [lsvb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lsvb_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [lsvb_pkg::PHI_W-1:0]    level_set_i,
  input  logic [lsvb_pkg::WIDTH_W-1:0]         cell_width_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lsvb_pkg::VISC_W-1:0]          viscosity_o,
  output logic [lsvb_pkg::H_W-1:0]             fluid_fraction_o
);

  // --------------------------------------------------------------------------
  // Local sizes
  // --------------------------------------------------------------------------
  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned POS_W  = 16 + IDX_W;
  localparam int unsigned SW     = lsvb_pkg::SINE_W;
  localparam int unsigned FW     = lsvb_pkg::FRAC_W;
  localparam int unsigned AW     = lsvb_pkg::ALPHA_W;
  localparam int unsigned QW     = lsvb_pkg::QUOT_W;
  localparam int unsigned HW     = lsvb_pkg::H_W;
  localparam int unsigned PW     = lsvb_pkg::PROD_W;
  localparam int unsigned IPROD_W = SW + FW;
  localparam int unsigned GPROD_W = SW + 30;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_TABLE_ENTRIES);

  typedef enum logic [lsvb_pkg::CFG_IDX_W-1:0] {
    CFG_FLUID_VISC      = 2'd0,
    CFG_SOLID_VISC      = 2'd1,
    CFG_INTERFACE_CELLS = 2'd2
  } cfg_reg_e;

  // --------------------------------------------------------------------------
  // Quarter-wave sine table, built at elaboration
  // Entry k holds sin(pi/2 * k / SINE_TABLE_ENTRIES) in Q2.30 from a
  // truncating Taylor series.
  // --------------------------------------------------------------------------
  typedef logic [SW-1:0] sine_rom_t [SINE_TABLE_ENTRIES + 1];

  function automatic logic [63:0] series_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int i = 1; i <= int'(lsvb_pkg::SERIES_TERMS); i++) begin
      term = ((term * x2) >> 30) / lsvb_pkg::SERIES_DIV[i-1];
      if ((i % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    for (int k = 0; k <= int'(SINE_TABLE_ENTRIES); k++) begin
      x = (lsvb_pkg::HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_ENTRIES / 2))
          / 64'(SINE_TABLE_ENTRIES);
      rom[k] = SW'(series_sine(x));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [lsvb_pkg::VISC_W-1:0]  fluid_visc_q;
  logic [lsvb_pkg::VISC_W-1:0]  solid_visc_q;
  logic [lsvb_pkg::CELLS_W-1:0] cells_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fluid_visc_q <= lsvb_pkg::FLUID_VISC_RST;
      solid_visc_q <= lsvb_pkg::SOLID_VISC_RST;
      cells_q      <= lsvb_pkg::CELLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLUID_VISC:      fluid_visc_q <= cfg_wdata_i;
        CFG_SOLID_VISC:      solid_visc_q <= cfg_wdata_i;
        CFG_INTERFACE_CELLS: cells_q      <= cfg_wdata_i[lsvb_pkg::CELLS_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline valid bits and stage enables
  // A stage loads when it is empty or the stage after it loads this cycle.
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic s6_valid_q, s7_valid_q, s8_valid_q, s9_valid_q, out_valid_q;
  logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_out;
  logic div_ready, div_valid;

  assign en_out = !out_valid_q || !out_stall_i;
  assign en_s9  = !s9_valid_q || en_out;
  assign en_s8  = !s8_valid_q || en_s9;
  assign en_s7  = !s7_valid_q || en_s8;
  assign en_s6  = !s6_valid_q || en_s7;
  assign en_s5  = !s5_valid_q || en_s6;
  assign en_s4  = !s4_valid_q || en_s5;
  assign en_s3  = !s3_valid_q || en_s4;
  assign en_s2  = !s2_valid_q || div_ready;
  assign en_s1  = !s1_valid_q || en_s2;

  assign in_stall_o = !en_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_s1)  s1_valid_q  <= in_valid_i;
      if (en_s2)  s2_valid_q  <= s1_valid_q;
      if (en_s3)  s3_valid_q  <= div_valid;
      if (en_s4)  s4_valid_q  <= s3_valid_q;
      if (en_s5)  s5_valid_q  <= s4_valid_q;
      if (en_s6)  s6_valid_q  <= s5_valid_q;
      if (en_s7)  s7_valid_q  <= s6_valid_q;
      if (en_s8)  s8_valid_q  <= s7_valid_q;
      if (en_s9)  s9_valid_q  <= s8_valid_q;
      if (en_out) out_valid_q <= s9_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: half-width alpha = cells * width (Q24.24), |level set|
  // --------------------------------------------------------------------------
  logic [lsvb_pkg::PHI_W-1:0] phi_u;
  logic [lsvb_pkg::MAG_W-1:0] mag_d;
  logic [AW-1:0]              alpha_d;

  logic [AW-1:0]              s1_alpha_q;
  logic [lsvb_pkg::MAG_W-1:0] s1_mag_q;
  logic                       s1_neg_q;

  assign phi_u   = level_set_i;
  assign mag_d   = phi_u[lsvb_pkg::PHI_W-1] ? (~phi_u + 32'd1) : phi_u;
  assign alpha_d = cells_q * cell_width_i;

  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      s1_alpha_q <= alpha_d;
      s1_mag_q   <= mag_d;
      s1_neg_q   <= phi_u[lsvb_pkg::PHI_W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: range test and dividend for u = round(|phi| * 2^24 / alpha)
  // The dividend's top part already sits below alpha inside the range,
  // so the divider only needs 17 quotient bits.
  // --------------------------------------------------------------------------
  logic [lsvb_pkg::NUM_W-1:0] num_d;
  lsvb_pkg::side_t            side_d;

  logic [AW-1:0]              s2_rem_q;
  logic [QW-1:0]              s2_low_q;
  logic [AW-1:0]              s2_alpha_q;
  lsvb_pkg::side_t            s2_side_q;

  assign num_d = {s1_mag_q, 24'd0} + {8'd0, (s1_alpha_q >> 1)};

  always_comb begin
    side_d.neg        = s1_neg_q;
    side_d.mag_zero   = (s1_mag_q == '0);
    side_d.alpha_zero = (s1_alpha_q == '0);
    side_d.beyond     = ({8'd0, s1_mag_q, 8'd0} > s1_alpha_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_s2) begin
      s2_rem_q   <= {9'd0, num_d[lsvb_pkg::NUM_W-1:QW]};
      s2_low_q   <= num_d[QW-1:0];
      s2_alpha_q <= s1_alpha_q;
      s2_side_q  <= side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: 17 stages
  // --------------------------------------------------------------------------
  logic [QW-1:0]   div_quot;
  lsvb_pkg::side_t div_side;

  lsvb_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s2_valid_q),
    .in_ready_o   (div_ready),
    .in_rem_i     (s2_rem_q),
    .in_low_i     (s2_low_q),
    .in_divisor_i (s2_alpha_q),
    .in_side_i    (s2_side_q),
    .out_valid_o  (div_valid),
    .out_ready_i  (en_s3),
    .out_quot_o   (div_quot),
    .out_side_o   (div_side)
  );

  // --------------------------------------------------------------------------
  // Stage 3: fold u onto the quarter wave, table position and fraction
  // --------------------------------------------------------------------------
  logic [QW-1:0]    u_d;
  logic [QW-1:0]    fold_d;
  logic [POS_W-1:0] pos_d;

  logic [IDX_W-1:0] s3_idx_q;
  logic [FW-1:0]    s3_frac_q;
  logic [QW-1:0]    s3_u_q;
  lsvb_pkg::side_t  s3_side_q;

  assign u_d    = (div_quot > lsvb_pkg::H_ONE) ? lsvb_pkg::H_ONE : div_quot;
  assign fold_d = (u_d <= lsvb_pkg::H_HALF) ? u_d : (lsvb_pkg::H_ONE - u_d);
  assign pos_d  = POS_W'(fold_d[15:0]) * POS_W'(SINE_TABLE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (en_s3) begin
      s3_idx_q  <= pos_d[FW +: IDX_W];
      s3_frac_q <= pos_d[FW-1:0];
      s3_u_q    <= u_d;
      s3_side_q <= div_side;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: table read at the position and the next entry
  // At the last entry the fraction is zero, so hold the index there.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] idx_hi_d;

  logic [SW-1:0]    s4_lo_q;
  logic [SW-1:0]    s4_hi_q;
  logic [FW-1:0]    s4_frac_q;
  logic [QW-1:0]    s4_u_q;
  lsvb_pkg::side_t  s4_side_q;

  assign idx_hi_d = (s3_idx_q == IDX_LAST) ? s3_idx_q : (s3_idx_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (en_s4) begin
      s4_lo_q   <= SINE_ROM[s3_idx_q];
      s4_hi_q   <= SINE_ROM[idx_hi_d];
      s4_frac_q <= s3_frac_q;
      s4_u_q    <= s3_u_q;
      s4_side_q <= s3_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: interpolation product |hi - lo| * frac
  // --------------------------------------------------------------------------
  logic            down_d;
  logic [SW-1:0]   span_d;

  logic [IPROD_W-1:0] s5_prod_q;
  logic [SW-1:0]      s5_lo_q;
  logic               s5_down_q;
  logic [QW-1:0]      s5_u_q;
  lsvb_pkg::side_t    s5_side_q;

  assign down_d = (s4_hi_q < s4_lo_q);
  assign span_d = down_d ? (s4_lo_q - s4_hi_q) : (s4_hi_q - s4_lo_q);

  always_ff @(posedge clk_i) begin
    if (en_s5) begin
      s5_prod_q <= IPROD_W'(span_d) * IPROD_W'(s4_frac_q);
      s5_lo_q   <= s4_lo_q;
      s5_down_q <= down_d;
      s5_u_q    <= s4_u_q;
      s5_side_q <= s4_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: sin(pi*u) in Q2.30
  // --------------------------------------------------------------------------
  logic [SW-1:0]   step_d;

  logic [SW-1:0]   s6_sine_q;
  logic [QW-1:0]   s6_u_q;
  lsvb_pkg::side_t s6_side_q;

  assign step_d = s5_prod_q[FW +: SW];

  always_ff @(posedge clk_i) begin
    if (en_s6) begin
      s6_sine_q <= s5_down_q ? (s5_lo_q - step_d) : (s5_lo_q + step_d);
      s6_u_q    <= s5_u_q;
      s6_side_q <= s5_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: sin/(2*pi) in Q0.32, truncated
  // --------------------------------------------------------------------------
  logic [GPROD_W-1:0] gprod_d;

  logic [SW-1:0]      s7_gs_q;
  logic [QW-1:0]      s7_u_q;
  lsvb_pkg::side_t    s7_side_q;

  assign gprod_d = GPROD_W'(s6_sine_q) * GPROD_W'(lsvb_pkg::INV_TWO_PI_Q32);

  always_ff @(posedge clk_i) begin
    if (en_s7) begin
      s7_gs_q   <= gprod_d[30 +: SW];
      s7_u_q    <= s6_u_q;
      s7_side_q <= s6_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: H = 0.5 +/- (u/2 + sin/(2*pi)), rounded to Q0.16, plus the
  // sharp-step and out-of-band cases
  // --------------------------------------------------------------------------
  logic [32:0]   g_sum_d;
  logic [31:0]   g_d;
  logic [32:0]   h32_d;
  logic [32:0]   h_rnd_d;
  logic [HW-1:0] h_smooth_d;
  logic [HW-1:0] h_step_d;
  logic [HW-1:0] h_d;

  logic [HW-1:0] s8_h_q;

  assign g_sum_d = {1'b0, s7_u_q, 15'd0} + {2'd0, s7_gs_q};
  assign g_d     = (g_sum_d > 33'h0_8000_0000) ? 32'h8000_0000 : g_sum_d[31:0];
  assign h32_d   = s7_side_q.neg ? (33'h0_8000_0000 - {1'b0, g_d})
                                 : (33'h0_8000_0000 + {1'b0, g_d});
  assign h_rnd_d = h32_d + 33'h0_0000_8000;

  always_comb begin
    h_smooth_d = (h_rnd_d[32:16] > lsvb_pkg::H_ONE) ? lsvb_pkg::H_ONE : h_rnd_d[32:16];
    h_step_d   = s7_side_q.neg ? lsvb_pkg::H_ZERO : lsvb_pkg::H_ONE;
    if (s7_side_q.alpha_zero) begin
      h_d = s7_side_q.mag_zero ? lsvb_pkg::H_HALF : h_step_d;
    end else if (s7_side_q.beyond) begin
      h_d = h_step_d;
    end else begin
      h_d = h_smooth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s8) begin
      s8_h_q <= h_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: blend products fluid*H and solid*(1-H)
  // --------------------------------------------------------------------------
  logic [PW-1:0] s9_fluid_q;
  logic [PW-1:0] s9_solid_q;
  logic [HW-1:0] s9_h_q;

  always_ff @(posedge clk_i) begin
    if (en_s9) begin
      s9_fluid_q <= PW'(fluid_visc_q) * PW'(s8_h_q);
      s9_solid_q <= PW'(solid_visc_q) * PW'(lsvb_pkg::H_ONE - s8_h_q);
      s9_h_q     <= s8_h_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: round, saturate at the Q16.16 maximum
  // --------------------------------------------------------------------------
  logic [PW:0]   mix_sum_d;
  logic [31:0]   visc_d;

  logic [lsvb_pkg::VISC_W-1:0] visc_q;
  logic [HW-1:0]               frac_out_q;

  assign mix_sum_d = {1'b0, s9_fluid_q} + {1'b0, s9_solid_q} + (PW+1)'(32'h8000);
  assign visc_d    = (mix_sum_d[PW:48] != '0) ? 32'hFFFF_FFFF : mix_sum_d[47:16];

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      visc_q     <= visc_d;
      frac_out_q <= s9_h_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign viscosity_o      = visc_q;
  assign fluid_fraction_o = frac_out_q;

endmodule

### sv/lsvb_chk.sv
// ----------------------------------------------------------------------------
// Level-set viscosity blend: port checker
// Watches the top level's ports and flags broken output behavior.
// ----------------------------------------------------------------------------
`include "level_set_viscosity_blend_macros.svh"

module lsvb_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_we_i,
  input logic [lsvb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input logic [lsvb_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [lsvb_pkg::PHI_W-1:0]    level_set_i,
  input logic [lsvb_pkg::WIDTH_W-1:0]         cell_width_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [lsvb_pkg::VISC_W-1:0]          viscosity_o,
  input logic [lsvb_pkg::H_W-1:0]             fluid_fraction_o
);

  // Fraction never exceeds one
  `LSVB_ASSERT_IMP(a_fraction_range, clk_i, rst_ni, out_valid_o, fluid_fraction_o <= lsvb_pkg::H_ONE, "fluid fraction above one")

  // Input side stalls only when a result word is backed up at the output
  `LSVB_ASSERT_IMP(a_stall_source, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled with output free")

  // Hold a stalled result word
  `LSVB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(viscosity_o) && $stable(fluid_fraction_o), "stalled result word changed")

endmodule

bind level_set_viscosity_blend lsvb_chk u_lsvb_chk (.*);

### tb/sv/level_set_viscosity_blend_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Level-set viscosity blend: self-checking testbench
// Streams grid words through the block under random sender gaps and receiver
// stalls, predicts the smoothed Heaviside fraction and blended viscosity of
// every accepted word, and compares each result word in order.
// ----------------------------------------------------------------------------
module level_set_viscosity_blend_test;
  import lsvb_pkg::*;

  localparam int unsigned TAB_N            = SINE_TABLE_ENTRIES_DEF;
  localparam int unsigned RANDOM_PER_PHASE = 165;
  localparam int unsigned DRAIN_CYCLES     = 32;    // pipeline is 27 deep
  localparam int unsigned HOLD_CYCLES      = 120;   // long output hold-off
  localparam int unsigned HOLD_PERIOD      = 2500;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLUID_VISC      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOLID_VISC      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERFACE_CELLS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED        = 2'd3;

  typedef struct packed {
    logic signed [PHI_W-1:0] level_set;
    logic [WIDTH_W-1:0]      cell_width;
  } grid_word_t;

  typedef struct packed {
    logic [VISC_W-1:0] viscosity;
    logic [H_W-1:0]    fraction;
  } blend_t;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata_i  = '0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_stall_o;
  logic signed [PHI_W-1:0]   level_set_i  = '0;
  logic [WIDTH_W-1:0]        cell_width_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i  = 1'b0;
  logic [VISC_W-1:0]         viscosity_o;
  logic [H_W-1:0]            fluid_fraction_o;

  // Shadow copy of the configuration registers
  logic [VISC_W-1:0]  fluid_visc  = FLUID_VISC_RST;
  logic [VISC_W-1:0]  solid_visc  = SOLID_VISC_RST;
  logic [CELLS_W-1:0] iface_cells = CELLS_RST;

  longint unsigned sine_q30 [0:TAB_N];   // quarter-wave sine, Q2.30

  grid_word_t pending_words[$];           // words waiting for the driver
  blend_t     blend_exp[$];               // predicted results, oldest first
  blend_t     head_exp;
  int         fail_count = 0;

  // Sender state
  logic        word_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver state
  rx_mode_t    rx_mode    = RX_FLOW;
  int unsigned seg_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned rx_cycles  = 0;

  always #5 clk_i = ~clk_i;

  level_set_viscosity_blend #(
    .SINE_TABLE_ENTRIES(TAB_N)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .level_set_i     (level_set_i),
    .cell_width_i    (cell_width_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .viscosity_o     (viscosity_o),
    .fluid_fraction_o(fluid_fraction_o)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Truncating Q2.30 Taylor series of sin(x)
  function automatic longint unsigned taylor_sine(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int i = 1; i <= SERIES_TERMS; i++) begin
      term = ((term * x2) >> 30) / longint'(4 * i * i + 2 * i);
      if (i % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // sin(pi*u) for u in Q0.16; fold onto the first quarter, interpolate the table
  function automatic longint unsigned sine_of_pi(longint unsigned u);
    longint unsigned v;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    v    = (u <= 32768) ? u : 65536 - u;
    pos  = v * TAB_N;
    idx  = pos >> FRAC_W;
    frac = pos & 64'h7FFF;
    if (idx >= TAB_N) return sine_q30[TAB_N];
    lo = sine_q30[idx];
    hi = sine_q30[idx + 1];
    if (hi < lo) return lo - (((lo - hi) * frac) >> 15);
    return lo + (((hi - lo) * frac) >> 15);
  endfunction

  // Smoothed Heaviside of the level set over half-width alpha (Q24.24)
  function automatic logic [H_W-1:0] smooth_step(bit [PHI_W-1:0] phi,
                                                 longint unsigned alpha);
    bit              neg;
    longint unsigned mag;
    longint unsigned u;
    longint unsigned g;
    longint unsigned h32;
    longint unsigned h;
    neg = phi[PHI_W-1];
    mag = neg ? 64'h1_0000_0000 - phi : phi;
    // sharp step when there is no smoothing band
    if (alpha == 0) begin
      if (mag == 0) return H_HALF;
      return neg ? H_ZERO : H_ONE;
    end
    if ((mag << 8) > alpha) return neg ? H_ZERO : H_ONE;
    u = ((mag << 24) + (alpha >> 1)) / alpha;
    if (u > 65536) u = 65536;
    g = (u << 15) + ((sine_of_pi(u) * INV_TWO_PI_Q32) >> 30);
    if (g > 64'h8000_0000) g = 64'h8000_0000;
    h32 = neg ? 64'h8000_0000 - g : 64'h8000_0000 + g;
    h   = (h32 + 64'h8000) >> 16;
    if (h > 65536) h = 65536;
    return h[H_W-1:0];
  endfunction

  function automatic blend_t blend_predict(logic signed [PHI_W-1:0] level_set,
                                           logic [WIDTH_W-1:0] cell_width);
    longint unsigned cells;
    longint unsigned width;
    longint unsigned h;
    longint unsigned mix;
    blend_t          res;
    cells = iface_cells;
    width = cell_width;
    h     = smooth_step(level_set, cells * width);
    mix   = (longint'(fluid_visc) * h + longint'(solid_visc) * (65536 - h) + 64'h8000) >> 16;
    if (mix > 64'hFFFF_FFFF) mix = 64'hFFFF_FFFF;
    res.viscosity = mix[VISC_W-1:0];
    res.fraction  = h[H_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_word(logic signed [PHI_W-1:0] level_set, logic [WIDTH_W-1:0] cell_width);
    grid_word_t gw;
    gw.level_set  = level_set;
    gw.cell_width = cell_width;
    pending_words.push_back(gw);
  endtask

  // Mostly words inside the smoothing band, some on its edge, some anywhere
  function automatic grid_word_t random_word();
    grid_word_t      gw;
    logic [31:0]     width;
    longint unsigned lim;
    longint unsigned mag;
    bit              neg;
    int unsigned     kind;
    case ($urandom_range(0, 9))
      0, 1:          width = $urandom;
      2, 3, 4, 5, 6: width = $urandom_range(1, 32'h0004_0000);
      default:       width = $urandom_range(1, 32'h0100_0000);
    endcase
    if (width == 0) width = 1;
    lim = (longint'(iface_cells) * width) >> 8;
    if (lim > 64'h8000_0000) lim = 64'h8000_0000;
    kind = $urandom_range(0, 9);
    neg  = $urandom_range(0, 1);
    gw.cell_width = width;
    if (kind >= 7) begin
      gw.level_set = $urandom;
      return gw;
    end
    mag = (kind == 6) ? lim : {$urandom, $urandom} % (lim + 1);
    if (!neg && mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    gw.level_set = neg ? -32'(mag) : 32'(mag);
    return gw;
  endfunction

  // Write one register at the next falling edge and mirror it in the shadow
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    case (idx)
      REG_FLUID_VISC:      fluid_visc  = data;
      REG_SOLID_VISC:      solid_visc  = data;
      REG_INTERFACE_CELLS: iface_cells = data[CELLS_W-1:0];
      default: ;  // unmapped index: the block drops the write
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Wait until every queued word went in and every result came out
  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || blend_exp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of words with random gaps, driven at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      // hold the offered word until the block takes it
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left   <= gap_left - 1;
    end else if (pending_words.size() != 0) begin
      level_set_i  <= pending_words[0].level_set;
      cell_width_i <= pending_words[0].cell_width;
      void'(pending_words.pop_front());
      in_valid_i   <= 1'b1;
      if (burst_left <= 1) begin
        // end of burst: pick the next burst and the gap before it
        burst_left <= $urandom_range(1, 48);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Record each accepted input word and predict its result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        blend_exp.push_back(blend_predict(level_set_i, cell_width_i));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, with a periodic long hold-off
  // that backs the pipeline up into the input while the sender keeps offering
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (rx_cycles % HOLD_PERIOD == 1000) begin
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_CYCLES;
      end else begin
        if (seg_left == 0) begin
          rx_mode  <= rx_mode_t'($urandom_range(0, 3));
          seg_left <= $urandom_range(8, 200);
        end else begin
          seg_left <= seg_left - 1;
        end
        case (rx_mode)
          RX_FLOW:   out_stall_i <= 1'b0;
          RX_LIGHT:  out_stall_i <= ($urandom_range(0, 2) == 0);
          RX_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_stall_i <= ~out_stall_i;
          default:   out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blend_exp.size() == 0) begin
        $error("result word with nothing expected: viscosity %h fluid_fraction %h",
               viscosity_o, fluid_fraction_o);
        fail_count++;
      end else begin
        head_exp = blend_exp.pop_front();
        if (viscosity_o !== head_exp.viscosity) begin
          $error("viscosity: expected %h, got %h", head_exp.viscosity, viscosity_o);
          fail_count++;
        end
        if (fluid_fraction_o !== head_exp.fraction) begin
          $error("fluid_fraction: expected %h, got %h", head_exp.fraction, fluid_fraction_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k <= TAB_N; k++) begin
      sine_q30[k] = taylor_sine((HALF_PI_Q30 * k + TAB_N / 2) / TAB_N);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words at the reset configuration (half-width of two cells)
    push_word(32'sd0, 32'd65536);
    push_word(32'sd1, 32'd65536);
    push_word(-32'sd1, 32'd65536);
    push_word(32'sh7FFF_FFFF, 32'd1);
    push_word(32'sh8000_0000, 32'd1);
    push_word(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    push_word(32'sh8000_0000, 32'hFFFF_FFFF);
    push_word(32'sd131072, 32'd65536);     // exactly at +alpha
    push_word(-32'sd131072, 32'd65536);    // exactly at -alpha
    push_word(32'sd131073, 32'd65536);     // just past the band
    push_word(-32'sd131073, 32'd65536);
    push_word(32'sd65536, 32'd65536);      // half way into the band
    push_word(-32'sd65536, 32'd65536);
    push_word(32'sd32768, 32'd65536);
    push_word(32'sd98304, 32'd65536);
    push_word(-32'sd98304, 32'd65536);
    push_word(32'sd0, 32'd1);
    push_word(32'sd2, 32'd1);              // band edge at the smallest width
    push_word(-32'sd2, 32'd1);
    push_word(32'sd1, 32'd1);
    push_word(32'sd0, 32'hFFFF_FFFF);
    push_word(32'sh4000_0000, 32'hFFFF_FFFF);
    drain();

    // Random phases, each at its own configuration
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_reg(REG_FLUID_VISC, $urandom);
          write_reg(REG_SOLID_VISC, $urandom);
          write_reg(REG_INTERFACE_CELLS, CELLS_RST);
        end
        1: begin
          write_reg(REG_FLUID_VISC, '0);
          write_reg(REG_SOLID_VISC, '1);
          write_reg(REG_INTERFACE_CELLS, 32'h0000_FFFF);
        end
        2: begin
          write_reg(REG_FLUID_VISC, '1);
          write_reg(REG_SOLID_VISC, '0);
          write_reg(REG_INTERFACE_CELLS, 32'd1);
        end
        3: begin
          // zero half-width: sharp step, including the exact zero level set
          write_reg(REG_FLUID_VISC, $urandom);
          write_reg(REG_INTERFACE_CELLS, 32'd0);
          push_word(32'sd0, 32'd1);
          push_word(32'sd1, 32'd1);
          push_word(-32'sd1, 32'd1);
          push_word(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
          push_word(32'sh8000_0000, 32'd7);
        end
        4: begin
          write_reg(REG_FLUID_VISC, '1);
          write_reg(REG_SOLID_VISC, '1);
          write_reg(REG_INTERFACE_CELLS, 32'd256);
        end
        5: begin
          write_reg(REG_FLUID_VISC, $urandom);
          write_reg(REG_SOLID_VISC, $urandom);
          write_reg(REG_INTERFACE_CELLS, $urandom_range(1, 4096));
        end
        6: begin
          // the unmapped index must leave every register alone
          write_reg(REG_UNMAPPED, $urandom);
          write_reg(REG_FLUID_VISC, $urandom_range(0, 32'h0010_0000));
          write_reg(REG_INTERFACE_CELLS, $urandom);
        end
        default: begin
          write_reg(REG_FLUID_VISC, $urandom);
          write_reg(REG_SOLID_VISC, $urandom);
          write_reg(REG_INTERFACE_CELLS, $urandom_range(256, 1024));
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_words.push_back(random_word());
      end
      drain();
    end

    if (fail_count == 0 && blend_exp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
